// ----- src/acfd_pkg.sv -----
// Shared constants, types and helper functions for the ASCII CAN frame decoder.
// Depends on nothing; acfd_dec and the top level import it.
package acfd_pkg;

  localparam int LineDepth     = 32;
  localparam int ShortIdDigits = 3;
  localparam int LongIdDigits  = 8;
  localparam int AddrW         = $clog2(LineDepth);
  localparam int CntW          = $clog2(LineDepth + 1);
  localparam int MinLineChars  = 4;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChBel   = 8'h07;
  localparam logic [7:0] ChLowT  = 8'h74;
  localparam logic [7:0] ChLowR  = 8'h72;
  localparam logic [7:0] ChUpT   = 8'h54;
  localparam logic [7:0] ChUpR   = 8'h52;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChEight = 8'h38;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;

  typedef struct packed {
    logic [31:0] frame_id;
    logic        extended;
    logic        remote;
    logic [3:0]  length;
    logic [63:0] payload;
  } dec_res_t;

  typedef struct packed {
    logic done;
    logic ok;
  } dec_stat_t;

  function automatic logic hex_ok(input logic [7:0] ch);
    hex_ok = (ch inside {[ChZero:ChNine], [ChLowA:ChLowF], [ChUpA:ChUpF]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] ch);
    logic [7:0] v;
    if (ch inside {[ChZero:ChNine]}) begin
      v = ch - ChZero;
    end else if (ch inside {[ChLowA:ChLowF]}) begin
      v = ch - ChLowA + 8'd10;
    end else begin
      v = ch - ChUpA + 8'd10;
    end
    hex_val = v[3:0];
  endfunction

endpackage

// ----- src/acfd_if.sv -----
// Request and result channel interfaces of the ASCII CAN frame decoder.
// Standalone; used by the top level ports.
interface acfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       byte_error;

  modport source (output valid, output rx_byte, output byte_error, input ready);
  modport sink (input valid, input rx_byte, input byte_error, output ready);
endinterface

interface acfd_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] frame_id;
  logic        extended;
  logic        remote;
  logic [3:0]  length;
  logic [63:0] payload;

  modport source (output valid, output status, output frame_id, output extended,
                  output remote, output length, output payload, input ready);
  modport sink (input valid, input status, input frame_id, input extended,
                input remote, input length, input payload, output ready);
endinterface

// ----- src/acfd_ram.sv -----
// Generic single write port, single read port RAM with a registered read.
// Standalone; holds the received text line.
module acfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/acfd_dec.sv -----
// Line parser: walks the stored line one character per cycle through the RAM read port.
// Depends on acfd_pkg.
module acfd_dec (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [acfd_pkg::CntW-1:0]   line_len_i,
  output logic [acfd_pkg::AddrW-1:0]  raddr_o,
  input  logic [7:0]                  rdata_i,
  output acfd_pkg::dec_stat_t         stat_o,
  output acfd_pkg::dec_res_t          res_o
);
  import acfd_pkg::*;

  logic             busy_q, dvalid_q;
  logic [AddrW-1:0] rd_addr_q, idx_q, nd, off;
  logic [CntW-1:0]  line_len_q;
  dec_res_t         res_q, res_d;
  logic             done, fail;
  logic [7:0]       dig;
  logic [5:0]       nib_pos;

  assign nd      = res_q.extended ? AddrW'(LongIdDigits) : AddrW'(ShortIdDigits);
  assign off     = idx_q - nd - AddrW'(2);
  assign nib_pos = {off[3:1], ~off[0], 2'b00};

  always_comb begin
    res_d = res_q;
    done  = 1'b0;
    fail  = 1'b0;
    dig   = rdata_i - ChZero;
    if (dvalid_q) begin
      if (CntW'(idx_q) >= line_len_q) begin
        fail = 1'b1;
      end else if (idx_q == '0) begin
        case (rdata_i)
          ChLowT: begin
            res_d.extended = 1'b0;
            res_d.remote   = 1'b0;
          end
          ChLowR: begin
            res_d.extended = 1'b0;
            res_d.remote   = 1'b1;
          end
          ChUpT: begin
            res_d.extended = 1'b1;
            res_d.remote   = 1'b0;
          end
          ChUpR: begin
            res_d.extended = 1'b1;
            res_d.remote   = 1'b1;
          end
          default: fail = 1'b1;
        endcase
      end else if (idx_q <= nd) begin
        if (hex_ok(rdata_i)) begin
          res_d.frame_id = {res_q.frame_id[27:0], hex_val(rdata_i)};
        end else begin
          fail = 1'b1;
        end
      end else if (idx_q == nd + AddrW'(1)) begin
        if (rdata_i inside {[ChZero:ChEight]}) begin
          res_d.length = dig[3:0];
          done = res_q.remote || (dig[3:0] == 4'd0);
        end else begin
          fail = 1'b1;
        end
      end else begin
        if (hex_ok(rdata_i)) begin
          res_d.payload = res_q.payload | (64'(hex_val(rdata_i)) << nib_pos);
          done = (CntW'(off) + CntW'(1)) == CntW'({res_q.length, 1'b0});
        end else begin
          fail = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      dvalid_q  <= 1'b0;
      rd_addr_q <= '0;
    end else if (start_i) begin
      busy_q    <= 1'b1;
      dvalid_q  <= 1'b0;
      rd_addr_q <= '0;
    end else if (busy_q) begin
      if (done || fail) begin
        busy_q   <= 1'b0;
        dvalid_q <= 1'b0;
      end else begin
        dvalid_q  <= 1'b1;
        rd_addr_q <= rd_addr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      res_q      <= '0;
      line_len_q <= line_len_i;
    end else begin
      res_q <= res_d;
    end
    idx_q <= rd_addr_q;
  end

  assign raddr_o     = rd_addr_q;
  assign stat_o.done = done || fail;
  assign stat_o.ok   = done && !fail;
  assign res_o       = res_d;

endmodule

// ----- src/ascii_can_frame_decoder.sv -----
// Top level of the ASCII CAN frame decoder: line collection, overflow handling, result register.
// Depends on acfd_pkg, acfd_if, acfd_ram and acfd_dec.
//
//   port     dir  carries
//   rx_i     in   rx_byte, byte_error: one received character per request
//   frame_o  out  status, frame_id, extended, remote, length, payload
//
// An error-flagged byte or an ordinary character that fits the line leaves rx_i ready for the next one.
// A terminator that starts a decode holds off rx_i while the parser reads the line one character
// at a time through the single RAM read port.
// An overflow result passes through the result register and the EMIT state to the output register.
// rx_i is held off during a decode and while a new result waits in EMIT to load the output register.
// Reset clears the character count and the error flag; the line RAM is not cleared.
module ascii_can_frame_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  acfd_in_if.sink    rx_i,
  acfd_out_if.source frame_o
);
  import acfd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEC  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             err_q, err_d;
  logic             accept, is_term, we, start, res_status_q, res_status_d;
  logic             out_valid_q, out_valid_d, load_out;
  logic [AddrW-1:0] raddr;
  logic [7:0]       rdata;
  dec_stat_t        dec_stat;
  dec_res_t         dec_res, res_q, res_d, out_q;
  logic             out_status_q;

  assign rx_i.ready = (state_q == ST_IDLE);
  assign accept     = rx_i.valid && rx_i.ready;
  assign is_term    = rx_i.rx_byte inside {ChCr, ChBel};
  assign we         = accept && !rx_i.byte_error && !is_term && !err_q &&
                      (cnt_q < CntW'(LineDepth));
  assign start      = accept && !rx_i.byte_error && is_term && !err_q &&
                      (cnt_q > CntW'(MinLineChars));
  assign load_out   = (state_q == ST_EMIT) && (!out_valid_q || frame_o.ready);

  acfd_ram #(.Width(8), .Depth(LineDepth)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (rx_i.rx_byte),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  acfd_dec u_dec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .line_len_i (cnt_q),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .stat_o     (dec_stat),
    .res_o      (dec_res)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    err_d        = err_q;
    res_d        = res_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    if (frame_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (rx_i.byte_error) begin
            err_d = 1'b1;
          end else if (is_term) begin
            err_d = 1'b0;
            cnt_d = '0;
            if (start) begin
              state_d = ST_DEC;
            end
          end else if (!err_q) begin
            if (cnt_q < CntW'(LineDepth)) begin
              cnt_d = cnt_q + CntW'(1);
            end else begin
              err_d        = 1'b1;
              res_d        = '0;
              res_status_d = 1'b1;
              state_d      = ST_EMIT;
            end
          end
        end
      end
      ST_DEC: begin
        if (dec_stat.done) begin
          res_d        = dec_res;
          res_status_d = 1'b0;
          state_d      = dec_stat.ok ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q        <= res_d;
    res_status_q <= res_status_d;
    if (load_out) begin
      out_q        <= res_q;
      out_status_q <= res_status_q;
    end
  end

  assign frame_o.valid    = out_valid_q;
  assign frame_o.status   = out_status_q;
  assign frame_o.frame_id = out_q.frame_id;
  assign frame_o.extended = out_q.extended;
  assign frame_o.remote   = out_q.remote;
  assign frame_o.length   = out_q.length;
  assign frame_o.payload  = out_q.payload;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_stat.done |-> state_q == ST_DEC)
    else $error("Parser finished outside of a decode.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && res_status_q) |-> err_q)
    else $error("Overflow result pending without the error flag.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(LineDepth))
    else $error("Character count beyond the line depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> cnt_q == '0 && !err_q)
    else $error("Line state not cleared after a terminator.");

endmodule
